/* design/srb_pkg.sv */
// shared types and constants of the sequenced replay buffer
// no dependencies; every other design file but srb_ram imports this package

package srb_pkg;

	// sizing
	localparam int VENUE_SLOTS = 8;
	localparam int RING_DEPTH  = 32;
	localparam int VIDX_W      = $clog2(VENUE_SLOTS);
	localparam int PTR_W       = $clog2(RING_DEPTH);
	localparam int CNT_W       = PTR_W + 1;
	localparam int ADDR_W      = VIDX_W + PTR_W;
	localparam int MEM_DEPTH   = VENUE_SLOTS * RING_DEPTH;

	// field widths
	localparam int CMD_W   = 2;
	localparam int VENUE_W = 3;
	localparam int SEQ_W   = 64;
	localparam int PAY_W   = 64;
	localparam int KIND_W  = 3;
	localparam int CTR_W   = 32;
	localparam int CFG_W   = 6;
	localparam int ENTRY_W = SEQ_W + PAY_W;

	// limit register after reset
	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(32);

	// beat layout
	localparam int IN_FIELDS_W  = VENUE_W + 2 * SEQ_W + PAY_W;
	localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int IN_PAD_W     = IN_DATA_W - IN_FIELDS_W;
	localparam int IN_USER_W    = CMD_W + 1;
	localparam int OUT_FIELDS_W = VENUE_W + SEQ_W + PAY_W + 2 * CTR_W;
	localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

	typedef enum logic [CMD_W-1:0] {
		CMD_RECORD,
		CMD_EVICT,
		CMD_LOOKUP,
		CMD_RECOVER
	} cmd_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_ACK     = 3'd0,
		KIND_EVENT   = 3'd1,
		KIND_HIT     = 3'd2,
		KIND_MISS    = 3'd3,
		KIND_SKIPPED = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RECORD,
		ST_WALK,
		ST_EMIT
	} state_t;

	// one result beat handed to the output register
	typedef struct packed {
		kind_t              kind;
		logic [VENUE_W-1:0] venue;
		logic [SEQ_W-1:0]   seq;
		logic [PAY_W-1:0]   pay;
		logic               last;
		logic [CTR_W-1:0]   req_cnt;
		logic [CTR_W-1:0]   rec_cnt;
	} result_t;

	// write of one venue's ring pointers
	typedef struct packed {
		logic              en;
		logic [VIDX_W-1:0] venue;
		logic [PTR_W-1:0]  head;
		logic [CNT_W-1:0]  cnt;
	} ring_upd_t;

endpackage

/* design/srb_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
// no dependencies

module srb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

/* design/srb_ring_tbl.sv */
// head and fill count of every venue ring, cleared by reset
// depends on srb_pkg

module srb_ring_tbl
	import srb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [VIDX_W-1:0] rd_venue,
	output logic [PTR_W-1:0]  rd_head,
	output logic [CNT_W-1:0]  rd_cnt,
	input  ring_upd_t         upd
);

	logic [PTR_W-1:0] head_q [VENUE_SLOTS];
	logic [CNT_W-1:0] cnt_q  [VENUE_SLOTS];

	// pointer update for one venue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int v = 0; v < VENUE_SLOTS; v++) begin
				head_q[v] <= '0;
				cnt_q[v]  <= '0;
			end
		end else if (upd.en) begin
			head_q[upd.venue] <= upd.head;
			cnt_q[upd.venue]  <= upd.cnt;
		end
	end

	assign rd_head = head_q[rd_venue];
	assign rd_cnt  = cnt_q[rd_venue];

endmodule

/* design/srb_out_stage.sv */
// output register of the result stream, frees the sequencer from the receiver
// depends on srb_pkg

module srb_out_stage
	import srb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  emit_valid,
	input  result_t               emit_data,
	output logic                  out_free,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic [KIND_W-1:0]     m_tuser,
	output logic                  m_tlast
);

	logic    valid_q;
	result_t res_q;

	assign out_free = !valid_q || m_tready;

	// beat held until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (emit_valid) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_valid) begin
			res_q <= emit_data;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tlast  = res_q.last;
	assign m_tuser  = res_q.kind;
	assign m_tdata  = {{OUT_PAD_W{1'b0}}, res_q.rec_cnt, res_q.req_cnt, res_q.pay,
		res_q.seq, res_q.venue};

endmodule

/* design/srb_ctrl.sv */
// command sequencer: record write, front walk with one shared compare unit,
// result sequencing and the two running counters; depends on srb_pkg

module srb_ctrl
	import srb_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// limit register
	input  logic               cfg_wr_en,
	input  logic [CFG_W-1:0]   cfg_wr_data,
	// command beat
	input  logic               in_valid,
	output logic               in_ready,
	input  cmd_t               in_cmd,
	input  logic [VENUE_W-1:0] in_venue,
	input  logic [SEQ_W-1:0]   in_seq,
	input  logic [SEQ_W-1:0]   in_rng_end,
	input  logic               in_gap,
	input  logic [PAY_W-1:0]   in_pay,
	// ring pointer table
	output logic [VIDX_W-1:0]  ring_rd_venue,
	input  logic [PTR_W-1:0]   ring_rd_head,
	input  logic [CNT_W-1:0]   ring_rd_cnt,
	output ring_upd_t          ring_upd,
	// event memory
	output logic               ram_we,
	output logic [ADDR_W-1:0]  ram_waddr,
	output logic [ENTRY_W-1:0] ram_wdata,
	output logic [ADDR_W-1:0]  ram_raddr,
	input  logic [ENTRY_W-1:0] ram_rdata,
	// result beats
	output logic               emit_valid,
	output result_t            emit_data,
	input  logic               out_free
);

	state_t             state_q, state_d;
	cmd_t               cmd_q;
	logic [CFG_W-1:0]   limit_cfg_q;
	logic [CTR_W-1:0]   req_cnt_q;
	logic [CTR_W-1:0]   rec_cnt_q;
	logic [VENUE_W-1:0] vf_q;
	logic [SEQ_W-1:0]   seq_q;
	logic [SEQ_W-1:0]   rng_end_q;
	logic [PAY_W-1:0]   pay_q;
	logic [PTR_W-1:0]   head_q;
	logic [CNT_W-1:0]   cnt_q;
	// walk control
	logic [CNT_W-1:0]   idx_q;
	logic               cmp_v_s1;
	logic [PTR_W-1:0]   cmp_idx_s1;
	logic [CNT_W-1:0]   drop_q;
	logic               have_max_q;
	logic [SEQ_W-1:0]   max_q;
	// pending result
	kind_t              pend_kind_q;
	logic [SEQ_W-1:0]   pend_seq_q;
	logic [PAY_W-1:0]   pend_pay_q;

	logic               accept;
	logic [VIDX_W-1:0]  vidx;
	logic [SEQ_W-1:0]   ent_seq;
	logic [PAY_W-1:0]   ent_pay;
	logic               q_lt_key;
	logic               q_eq_key;
	logic               q_in_rng;
	logic               new_max;
	logic               rec_hit;
	logic               pend_event;
	logic               walk_stall;
	logic               walk_push;
	logic               walk_stop;
	logic               walk_end;
	logic [PTR_W-1:0]   rd_idx;
	// record arithmetic
	logic               full;
	logic [CNT_W-1:0]   lim;
	logic [PTR_W-1:0]   h1;
	logic [CNT_W-1:0]   c1;
	logic [PTR_W-1:0]   slot;
	logic [CNT_W-1:0]   c2;
	logic [CNT_W-1:0]   trim;
	logic               over;
	logic [PTR_W-1:0]   rec_head;
	logic [CNT_W-1:0]   rec_cnt_new;

	assign accept        = in_valid && in_ready;
	assign vidx          = vf_q[VIDX_W-1:0];
	assign ring_rd_venue = in_venue[VIDX_W-1:0];

	// shared compare unit on the entry read back
	assign {ent_pay, ent_seq} = ram_rdata;
	assign q_lt_key   = ent_seq < seq_q;
	assign q_eq_key   = ent_seq == seq_q;
	assign q_in_rng   = !q_lt_key && (ent_seq <= rng_end_q);
	assign new_max    = !have_max_q || (ent_seq > max_q);
	assign pend_event = pend_kind_q == KIND_EVENT;
	assign rec_hit    = cmp_v_s1 && (cmd_q == CMD_RECOVER) && new_max && q_in_rng;
	assign walk_stall = rec_hit && pend_event && !out_free;
	assign walk_push  = rec_hit && pend_event && out_free;
	assign walk_stop  = cmp_v_s1 && ((cmd_q == CMD_EVICT) || (cmd_q == CMD_LOOKUP)) &&
		!q_lt_key;
	assign walk_end   = walk_stop || (!cmp_v_s1 && (idx_q >= cnt_q));
	assign rd_idx     = walk_stall ? cmp_idx_s1 : idx_q[PTR_W-1:0];

	// record: make room, append, trim to the limit
	always_comb begin
		if (limit_cfg_q == '0) begin
			lim = '0;
		end else if (int'(limit_cfg_q) > RING_DEPTH) begin
			lim = CNT_W'(RING_DEPTH);
		end else begin
			lim = CNT_W'(limit_cfg_q);
		end
		full        = cnt_q >= CNT_W'(RING_DEPTH);
		h1          = head_q + PTR_W'(full);
		c1          = cnt_q - CNT_W'(full);
		slot        = h1 + c1[PTR_W-1:0];
		c2          = c1 + CNT_W'(1);
		over        = c2 > lim;
		trim        = c2 - lim;
		rec_head    = over ? (h1 + trim[PTR_W-1:0]) : h1;
		rec_cnt_new = over ? lim : c2;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_cmd == CMD_RECORD) begin
						state_d = ST_RECORD;
					end else if ((in_cmd == CMD_RECOVER) && in_gap) begin
						state_d = ST_EMIT;
					end else begin
						state_d = ST_WALK;
					end
				end
			end
			ST_RECORD: begin
				state_d = ST_EMIT;
			end
			ST_WALK: begin
				if (walk_end) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready       = 1'b0;
		ram_we         = 1'b0;
		ram_waddr      = {vidx, slot};
		ram_wdata      = {pay_q, seq_q};
		ram_raddr      = {vidx, head_q + rd_idx};
		ring_upd.en    = 1'b0;
		ring_upd.venue = vidx;
		ring_upd.head  = rec_head;
		ring_upd.cnt   = rec_cnt_new;
		emit_valid     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_RECORD: begin
				ram_we      = 1'b1;
				ring_upd.en = 1'b1;
			end
			ST_WALK: begin
				emit_valid = walk_push;
				if (walk_end && (cmd_q == CMD_EVICT)) begin
					ring_upd.en   = 1'b1;
					ring_upd.head = head_q + drop_q[PTR_W-1:0];
					ring_upd.cnt  = cnt_q - drop_q;
				end
			end
			ST_EMIT: begin
				emit_valid = out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
		emit_data.kind    = pend_kind_q;
		emit_data.venue   = vf_q;
		emit_data.seq     = pend_seq_q;
		emit_data.pay     = pend_pay_q;
		emit_data.last    = state_q == ST_EMIT;
		emit_data.req_cnt = req_cnt_q;
		emit_data.rec_cnt = pend_event ? (rec_cnt_q + CTR_W'(1)) : rec_cnt_q;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cmd_q       <= CMD_RECORD;
			limit_cfg_q <= CFG_RESET;
			req_cnt_q   <= '0;
			rec_cnt_q   <= '0;
			idx_q       <= '0;
			cmp_v_s1    <= 1'b0;
			cmp_idx_s1  <= '0;
			drop_q      <= '0;
			have_max_q  <= 1'b0;
			pend_kind_q <= KIND_ACK;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				limit_cfg_q <= cfg_wr_data;
			end
			if (emit_valid && pend_event) begin
				rec_cnt_q <= rec_cnt_q + CTR_W'(1);
			end
			if (accept) begin
				cmd_q      <= in_cmd;
				idx_q      <= '0;
				cmp_v_s1   <= 1'b0;
				drop_q     <= '0;
				have_max_q <= 1'b0;
				if (in_cmd == CMD_RECOVER) begin
					req_cnt_q <= req_cnt_q + CTR_W'(1);
				end
				if (in_cmd == CMD_LOOKUP) begin
					pend_kind_q <= KIND_MISS;
				end else if ((in_cmd == CMD_RECOVER) && in_gap) begin
					pend_kind_q <= KIND_SKIPPED;
				end else begin
					pend_kind_q <= KIND_ACK;
				end
			end else if (state_q == ST_WALK) begin
				// issue the next entry read unless the compare stage holds
				if (!walk_stall) begin
					if (idx_q < cnt_q) begin
						cmp_v_s1   <= 1'b1;
						cmp_idx_s1 <= idx_q[PTR_W-1:0];
						idx_q      <= idx_q + CNT_W'(1);
					end else begin
						cmp_v_s1 <= 1'b0;
					end
				end
				if (cmp_v_s1 && (cmd_q == CMD_EVICT) && q_lt_key) begin
					drop_q <= CNT_W'(cmp_idx_s1) + CNT_W'(1);
				end
				if (cmp_v_s1 && (cmd_q == CMD_RECOVER) && !walk_stall && new_max) begin
					have_max_q <= 1'b1;
				end
				if (walk_stop && (cmd_q == CMD_LOOKUP) && q_eq_key) begin
					pend_kind_q <= KIND_HIT;
				end
				if (rec_hit && !walk_stall) begin
					pend_kind_q <= KIND_EVENT;
				end
			end
		end
	end

	// command fields and result data
	always_ff @(posedge clk) begin
		if (accept) begin
			vf_q       <= in_venue;
			seq_q      <= in_seq;
			rng_end_q  <= in_rng_end;
			pay_q      <= in_pay;
			head_q     <= ring_rd_head;
			cnt_q      <= ring_rd_cnt;
			pend_seq_q <= (in_cmd == CMD_LOOKUP) ? in_seq : '0;
			pend_pay_q <= '0;
		end else if (state_q == ST_WALK) begin
			if (cmp_v_s1 && (cmd_q == CMD_RECOVER) && !walk_stall && new_max) begin
				max_q <= ent_seq;
			end
			if (walk_stop && (cmd_q == CMD_LOOKUP) && q_eq_key) begin
				pend_pay_q <= ent_pay;
			end
			if (rec_hit && !walk_stall) begin
				pend_seq_q <= ent_seq;
				pend_pay_q <= ent_pay;
			end
		end
	end

endmodule

/* design/sequenced_replay_buffer.sv */
// top level of the sequenced replay buffer
// depends on srb_pkg, srb_ram, srb_ring_tbl, srb_ctrl and srb_out_stage
//
// Usage: commands arrive on the s_ channel, one beat per command. Each venue
// keeps a ring of up to 32 (sequence, payload) events in one shared memory.
// Record appends and trims to the limit register, evict drops front events
// below a sequence, lookup answers hit or miss, recover replays the events of
// a sequence range, last beat marked by m_tlast (one done beat if none match,
// one skipped beat when gap_too_large is set). Record and evict answer with
// one ack beat.
// Sequencing: one command at a time. A record holds the block through accept,
// memory write and result load. Evict, lookup and recover walk the venue ring
// front to back through the memory read port and one compare unit, one entry
// per cycle unless a stall holds the walk; a recover with gap_too_large set
// skips the walk.
// s_tready is high again the cycle after the last result beat is loaded.
// Stall: results pass through a one-beat output register; while it holds a beat,
// m_tready is low and a further beat is due, the walk holds in place.
// Reset: all rings are empty, both counters are zero and the limit is 32.
// The limit register may be written only while no command is in flight.

module sequenced_replay_buffer
	import srb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_W-1:0]      cfg_wr_data,  // max_events_per_venue
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// venue, sequence_req, range_end, event_payload, zero fill
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// command, gap_too_large
	input  logic [IN_USER_W-1:0]  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// out_venue, out_sequence, out_payload, requests_seen, recovered_count, zero fill
	output logic [OUT_DATA_W-1:0] m_tdata,
	// result_kind
	output logic [KIND_W-1:0]     m_tuser,
	output logic                  m_tlast
);

	logic [VIDX_W-1:0]  ring_rd_venue;
	logic [PTR_W-1:0]   ring_rd_head;
	logic [CNT_W-1:0]   ring_rd_cnt;
	ring_upd_t          ring_upd;
	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [ADDR_W-1:0]  ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;
	logic               emit_valid;
	result_t            emit_data;
	logic               out_free;

	// event store shared by all venues
	srb_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MEM_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	srb_ring_tbl u_ring_tbl (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_venue(ring_rd_venue),
		.rd_head (ring_rd_head),
		.rd_cnt  (ring_rd_cnt),
		.upd     (ring_upd)
	);

	// command beat fields
	srb_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.in_cmd       (cmd_t'(s_tuser[CMD_W-1:0])),
		.in_venue     (s_tdata[VENUE_W-1:0]),
		.in_seq       (s_tdata[VENUE_W +: SEQ_W]),
		.in_rng_end   (s_tdata[VENUE_W+SEQ_W +: SEQ_W]),
		.in_gap       (s_tuser[CMD_W]),
		.in_pay       (s_tdata[VENUE_W+2*SEQ_W +: PAY_W]),
		.ring_rd_venue(ring_rd_venue),
		.ring_rd_head (ring_rd_head),
		.ring_rd_cnt  (ring_rd_cnt),
		.ring_upd     (ring_upd),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.ram_raddr    (ram_raddr),
		.ram_rdata    (ram_rdata),
		.emit_valid   (emit_valid),
		.emit_data    (emit_data),
		.out_free     (out_free)
	);

	srb_out_stage u_out_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.emit_valid(emit_valid),
		.emit_data (emit_data),
		.out_free  (out_free),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

/* bench/tb_sequenced_replay_buffer.sv */
`timescale 1ns / 1ps
// self-checking bench for sequenced_replay_buffer: stream driver, stream monitor, ring predictor
// depends on srb_pkg and the design files under design/

module tb_sequenced_replay_buffer;
	import srb_pkg::*;

	// offsets of the fields inside the data beats
	localparam int I_SEQ = VENUE_W;
	localparam int I_HI  = I_SEQ + SEQ_W;
	localparam int I_PAY = I_HI + SEQ_W;
	localparam int O_SEQ = VENUE_W;
	localparam int O_PAY = O_SEQ + SEQ_W;
	localparam int O_REQ = O_PAY + PAY_W;
	localparam int O_REC = O_REQ + CTR_W;

	// one command beat
	typedef struct packed {
		cmd_t               cmd;
		logic [VENUE_W-1:0] venue;
		logic [SEQ_W-1:0]   seq_req;
		logic [SEQ_W-1:0]   range_hi;
		logic               gap;
		logic [PAY_W-1:0]   payload;
	} cmd_item_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_W-1:0]      cfg_wr_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [IN_USER_W-1:0]  s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [KIND_W-1:0]     m_tuser;
	logic                  m_tlast;

	sequenced_replay_buffer u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast)
	);

	always #4 clk = ~clk;

	// predictor state: per-venue event history, counters, limit
	logic [SEQ_W-1:0] hist_seq [VENUE_SLOTS][RING_DEPTH];
	logic [PAY_W-1:0] hist_pay [VENUE_SLOTS][RING_DEPTH];
	logic [PTR_W-1:0] hist_head [VENUE_SLOTS];
	logic [CNT_W-1:0] hist_cnt [VENUE_SLOTS];
	logic [CTR_W-1:0] recover_cmds = '0;
	logic [CTR_W-1:0] replayed_total = '0;
	logic [CFG_W-1:0] keep_limit = CFG_RESET;

	cmd_item_t cmds_pending[$];
	result_t   answers_due[$];
	cmd_item_t bus_item;
	int        offered = 0;
	int        taken = 0;
	int        beats_seen = 0;
	int        err_cnt = 0;

	// pacing knobs set per phase
	int tx_max_gap = 0;
	int rx_max_wait = 0;
	int hold_len = 0;
	int hold_trigger = 0;

	// stimulus bookkeeping: newest recorded sequence per venue
	logic [SEQ_W-1:0] last_seq [VENUE_SLOTS];

	initial begin
		for (int v = 0; v < VENUE_SLOTS; v++) begin
			hist_head[v] = '0;
			hist_cnt[v] = '0;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [PTR_W-1:0] ring_pos(int v, int i);
		return hist_head[v] + PTR_W'(i);
	endfunction

	function automatic void drop_front(int v);
		hist_head[v] = hist_head[v] + 1'b1;
		hist_cnt[v] = hist_cnt[v] - 1'b1;
	endfunction

	function automatic void push_answer(kind_t k, logic [VENUE_W-1:0] v, logic [SEQ_W-1:0] s,
			logic [PAY_W-1:0] p, logic l);
		result_t r;
		r.kind = k;
		r.venue = v;
		r.seq = s;
		r.pay = p;
		r.last = l;
		r.req_cnt = recover_cmds;
		r.rec_cnt = replayed_total;
		answers_due.insert(answers_due.size(), r);
	endfunction

	// update the history for one accepted command and queue the beats it answers with
	function automatic void answer_command(cmd_item_t c);
		int v;
		int lim;
		int i;
		int hits[$];
		logic [PTR_W-1:0] p;
		logic [SEQ_W-1:0] q;
		logic [SEQ_W-1:0] top;
		logic seen;
		logic found;
		logic [PAY_W-1:0] hit_pay;
		v = int'(c.venue) % VENUE_SLOTS;
		case (c.cmd)
			CMD_RECORD: begin
				lim = keep_limit;
				if (lim > RING_DEPTH)
					lim = RING_DEPTH;
				if (hist_cnt[v] >= RING_DEPTH)
					drop_front(v);
				p = ring_pos(v, hist_cnt[v]);
				hist_seq[v][p] = c.seq_req;
				hist_pay[v][p] = c.payload;
				hist_cnt[v] = hist_cnt[v] + 1'b1;
				while (hist_cnt[v] > lim)
					drop_front(v);
				push_answer(KIND_ACK, c.venue, '0, '0, 1'b1);
			end
			CMD_EVICT: begin
				while (hist_cnt[v] > 0 && hist_seq[v][ring_pos(v, 0)] < c.seq_req)
					drop_front(v);
				push_answer(KIND_ACK, c.venue, '0, '0, 1'b1);
			end
			CMD_LOOKUP: begin
				// first entry not below the key decides hit or miss
				found = 1'b0;
				hit_pay = '0;
				for (i = 0; i < hist_cnt[v]; i++) begin
					p = ring_pos(v, i);
					if (hist_seq[v][p] >= c.seq_req) begin
						found = (hist_seq[v][p] == c.seq_req);
						hit_pay = hist_pay[v][p];
						break;
					end
				end
				if (found)
					push_answer(KIND_HIT, c.venue, c.seq_req, hit_pay, 1'b1);
				else
					push_answer(KIND_MISS, c.venue, c.seq_req, '0, 1'b1);
			end
			default: begin
				recover_cmds = recover_cmds + 1'b1;
				if (c.gap) begin
					push_answer(KIND_SKIPPED, c.venue, '0, '0, 1'b1);
				end else begin
					// only entries above every earlier one are replayed
					seen = 1'b0;
					top = '0;
					for (i = 0; i < hist_cnt[v]; i++) begin
						p = ring_pos(v, i);
						q = hist_seq[v][p];
						if (!seen || q > top) begin
							if (q >= c.seq_req && q <= c.range_hi)
								hits.insert(hits.size(), p);
							top = q;
							seen = 1'b1;
						end
					end
					if (hits.size() == 0) begin
						push_answer(KIND_ACK, c.venue, '0, '0, 1'b1);
					end else begin
						for (i = 0; i < hits.size(); i++) begin
							replayed_total = replayed_total + 1'b1;
							push_answer(KIND_EVENT, c.venue, hist_seq[v][hits[i]],
								hist_pay[v][hits[i]], i == hits.size() - 1);
						end
					end
				end
			end
		endcase
	endfunction

	// command driver: one item per handshake, random gap drawn after each beat
	int tx_gap = 0;
	always @(negedge clk) begin : drv
		logic nv;
		cmd_item_t it;
		logic [IN_DATA_W-1:0] d;
		nv = s_tvalid;
		if (s_tvalid && taken == offered) begin
			nv = 1'b0;
			tx_gap = $urandom_range(0, tx_max_gap);
		end
		if (!nv) begin
			if (tx_gap > 0) begin
				tx_gap--;
			end else if (cmds_pending.size() > 0) begin
				it = cmds_pending[0];
				cmds_pending.delete(0);
				d = '0;
				d[VENUE_W-1:0] = it.venue;
				d[I_SEQ +: SEQ_W] = it.seq_req;
				d[I_HI +: SEQ_W] = it.range_hi;
				d[I_PAY +: PAY_W] = it.payload;
				s_tdata <= d;
				s_tuser <= {it.gap, it.cmd};
				bus_item = it;
				offered++;
				nv = 1'b1;
			end
		end
		s_tvalid <= nv;
	end

	// accepted command beats feed the predictor
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			answer_command(bus_item);
			taken++;
		end
	end

	// result receiver: random wait after each beat, plus an occasional long hold
	int beats_paced = 0;
	int rx_wait = 0;
	int hold_seen = 0;
	int hold_left = 0;
	always @(negedge clk) begin
		if (hold_trigger != hold_seen) begin
			hold_seen = hold_trigger;
			hold_left = hold_len;
		end
		if (beats_seen != beats_paced) begin
			beats_paced = beats_seen;
			rx_wait = $urandom_range(0, rx_max_wait);
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (rx_wait > 0) begin
			rx_wait--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %h, actual %h", name, want, got);
			err_cnt++;
		end
	endfunction

	// result monitor: each beat against the oldest answer due
	always @(posedge clk) begin : mon
		result_t r;
		if (arst_n && m_tvalid && m_tready) begin
			beats_seen++;
			if (answers_due.size() == 0) begin
				$error("result beat with nothing due: kind %0d venue %0d", m_tuser,
					m_tdata[VENUE_W-1:0]);
				err_cnt++;
			end else begin
				r = answers_due[0];
				answers_due.delete(0);
				check_field("result_kind", 64'(r.kind), 64'(m_tuser));
				check_field("out_venue", 64'(r.venue), 64'(m_tdata[VENUE_W-1:0]));
				check_field("out_sequence", r.seq, m_tdata[O_SEQ +: SEQ_W]);
				check_field("out_payload", r.pay, m_tdata[O_PAY +: PAY_W]);
				check_field("last", 64'(r.last), 64'(m_tlast));
				check_field("requests_seen", 64'(r.req_cnt), 64'(m_tdata[O_REQ +: CTR_W]));
				check_field("recovered_count", 64'(r.rec_cnt), 64'(m_tdata[O_REC +: CTR_W]));
			end
		end
	end

	task automatic queue_cmd(cmd_t c, int v, logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b,
			logic g, logic [PAY_W-1:0] p);
		cmd_item_t it;
		it.cmd = c;
		it.venue = VENUE_W'(v);
		it.seq_req = a;
		it.range_hi = b;
		it.gap = g;
		it.payload = p;
		cmds_pending.insert(cmds_pending.size(), it);
	endtask

	// random mix of commands; records mostly ascending near the venue's newest sequence, some noise
	task automatic gen_random(int hot);
		int v;
		int r;
		int k;
		logic [SEQ_W-1:0] a;
		logic [SEQ_W-1:0] b;
		logic g;
		v = ($urandom_range(0, 9) < 6) ? hot : $urandom_range(0, VENUE_SLOTS - 1);
		r = $urandom_range(0, 99);
		b = rand64();
		g = $urandom_range(0, 1);
		if (r < 45) begin
			k = $urandom_range(0, 19);
			if (k == 0) begin
				a = rand64();
				last_seq[v] = a;
			end else if (k == 1) begin
				a = last_seq[v];
			end else if (k == 2) begin
				a = last_seq[v] - $urandom_range(1, 8);
			end else begin
				a = last_seq[v] + $urandom_range(1, 4);
				last_seq[v] = a;
			end
			queue_cmd(CMD_RECORD, v, a, b, g, rand64());
		end else if (r < 58) begin
			a = ($urandom_range(0, 9) == 0) ? rand64() : last_seq[v] - $urandom_range(0, 12);
			queue_cmd(CMD_EVICT, v, a, b, g, rand64());
		end else if (r < 78) begin
			a = ($urandom_range(0, 6) == 0) ? rand64() : last_seq[v] - $urandom_range(0, 10);
			queue_cmd(CMD_LOOKUP, v, a, b, g, rand64());
		end else begin
			k = $urandom_range(0, 9);
			a = last_seq[v] - $urandom_range(0, 30);
			if (k == 0) begin
				a = '0;
				b = '1;
			end else if (k == 1) begin
				b = a - $urandom_range(1, 5);
			end else begin
				b = a + $urandom_range(0, 40);
			end
			g = ($urandom_range(0, 6) == 0);
			queue_cmd(CMD_RECOVER, v, a, b, g, rand64());
		end
	endtask

	// idle means nothing queued, nothing on the bus and no answer outstanding
	task automatic wait_drained();
		while (!(cmds_pending.size() == 0 && taken == offered && answers_due.size() == 0))
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_limit(logic [CFG_W-1:0] val);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= val;
		keep_limit = val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		repeat (2) @(negedge clk);
	endtask

	// run length guard
	initial begin
		#6000000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin : main
		for (int v = 0; v < VENUE_SLOTS; v++)
			last_seq[v] = rand64() >> 1;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		tx_max_gap = 17;
		rx_max_wait = 17;

		// directed: empty rings, duplicates, unordered history, extremes
		queue_cmd(CMD_LOOKUP, 0, '0, '1, 1'b0, '1);
		queue_cmd(CMD_RECOVER, 0, '0, '1, 1'b0, '0);
		queue_cmd(CMD_RECOVER, 0, '0, '1, 1'b1, '0);
		queue_cmd(CMD_EVICT, 1, '1, '0, 1'b1, '1);
		queue_cmd(CMD_RECORD, 0, '0, '0, 1'b0, '1);
		queue_cmd(CMD_RECORD, 0, 64'd10, '1, 1'b0, '0);
		queue_cmd(CMD_RECORD, 0, 64'd10, '0, 1'b0, {16{4'h5}});
		queue_cmd(CMD_RECORD, 0, 64'd5, '0, 1'b0, {16{4'hA}});
		queue_cmd(CMD_RECORD, 0, '1, '0, 1'b0, 64'd1);
		queue_cmd(CMD_LOOKUP, 0, '0, '0, 1'b0, '0);
		queue_cmd(CMD_LOOKUP, 0, 64'd10, '0, 1'b0, '0);
		queue_cmd(CMD_LOOKUP, 0, 64'd5, '0, 1'b0, '0);
		queue_cmd(CMD_LOOKUP, 0, 64'd7, '0, 1'b0, '0);
		queue_cmd(CMD_LOOKUP, 0, '1, '0, 1'b0, '0);
		queue_cmd(CMD_RECOVER, 0, '0, '1, 1'b0, '0);
		queue_cmd(CMD_RECOVER, 0, 64'd10, 64'd2, 1'b0, '0);
		queue_cmd(CMD_RECOVER, 0, 64'd11, 64'd100, 1'b0, '0);
		queue_cmd(CMD_EVICT, 0, 64'd10, '0, 1'b0, '0);
		queue_cmd(CMD_RECOVER, 0, '0, '1, 1'b0, '0);
		queue_cmd(CMD_RECORD, 7, 64'd3, '1, 1'b1, rand64());
		queue_cmd(CMD_LOOKUP, 7, 64'd3, '0, 1'b0, '0);
		queue_cmd(CMD_EVICT, 0, '1, '0, 1'b0, '0);
		queue_cmd(CMD_RECOVER, 0, '0, '1, 1'b0, '0);
		queue_cmd(CMD_RECOVER, 7, '0, '1, 1'b1, '1);

		// limit of one event per venue
		write_limit(CFG_W'(1));
		repeat (14) gen_random(0);

		// limit zero keeps nothing
		write_limit(CFG_W'(0));
		tx_max_gap = 0;
		repeat (10) gen_random(3);

		// oversize limit clamps to the ring depth; fill one ring against a held receiver
		write_limit('1);
		rx_max_wait = 0;
		hold_len = 300;
		hold_trigger++;
		last_seq[2] = rand64() >> 1;
		repeat (36) begin
			last_seq[2] = last_seq[2] + $urandom_range(1, 3);
			queue_cmd(CMD_RECORD, 2, last_seq[2], rand64(), 1'b0, rand64());
		end
		queue_cmd(CMD_RECOVER, 2, '0, '1, 1'b0, rand64());
		repeat (12) gen_random(2);

		// just above the depth
		write_limit(CFG_W'(33));
		tx_max_gap = 17;
		repeat (20) gen_random(4);

		// lowered limit trims only on the next record
		write_limit(CFG_W'(5));
		tx_max_gap = 0;
		rx_max_wait = 17;
		queue_cmd(CMD_RECOVER, 2, '0, '1, 1'b0, rand64());
		last_seq[2] = last_seq[2] + 1;
		queue_cmd(CMD_RECORD, 2, last_seq[2], rand64(), 1'b0, rand64());
		queue_cmd(CMD_RECOVER, 2, '0, '1, 1'b0, rand64());
		repeat (20) gen_random(2);

		// back to the reset limit, full idling on both sides
		write_limit(CFG_W'(32));
		tx_max_gap = 17;
		repeat (20) gen_random($urandom_range(0, VENUE_SLOTS - 1));

		wait_drained();
		repeat (40) @(negedge clk);
		if (err_cnt == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
